FILE: hw/rtl/srpd_pkg.sv
// ----------------------------------------------------------------------------
// srpd_pkg - shared definitions for the speed ramp / PD motor control core
// Field widths, register codes, reset values and default parameter values.
// ----------------------------------------------------------------------------
package srpd_pkg;

  // Transaction field widths
  localparam int CNT_W  = 32;
  localparam int TGT_W  = 12;
  localparam int GYRO_W = 24;
  localparam int WALL_W = 12;
  localparam int MODE_W = 2;
  localparam int DRV_W  = 16;
  localparam int ERR_W  = 32;

  localparam int IN_TDATA_W  = 2 * CNT_W + 2 * TGT_W + GYRO_W + 2 * WALL_W;
  localparam int IN_TUSER_W  = 1 + MODE_W;
  localparam int OUT_TDATA_W = 2 * DRV_W;

  // Configuration port
  localparam int REG_W    = 16;
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FWD_KP   = 3'd0,
    REG_FWD_KD   = 3'd1,
    REG_TURN_KP  = 3'd2,
    REG_TURN_KD  = 3'd3,
    REG_FWD_ACC  = 3'd4,
    REG_FWD_DEC  = 3'd5,
    REG_TURN_ACC = 3'd6,
    REG_TURN_DEC = 3'd7
  } cfg_reg_t;

  localparam logic [REG_W-1:0] RST_FWD_KP   = 16'd512;
  localparam logic [REG_W-1:0] RST_FWD_KD   = 16'd1024;
  localparam logic [REG_W-1:0] RST_TURN_KP  = 16'd256;
  localparam logic [REG_W-1:0] RST_TURN_KD  = 16'd3072;
  localparam logic [REG_W-1:0] RST_FWD_ACC  = 16'd154;
  localparam logic [REG_W-1:0] RST_FWD_DEC  = 16'd154;
  localparam logic [REG_W-1:0] RST_TURN_ACC = 16'd256;
  localparam logic [REG_W-1:0] RST_TURN_DEC = 16'd256;

  // Rotational feedback source; the unused code falls back to encoder plus gyro
  typedef enum logic [MODE_W-1:0] {
    FB_ENC_GYRO = 2'd0,
    FB_GYRO     = 2'd1,
    FB_ENC      = 2'd2
  } fb_mode_t;

  // Default parameter values
  localparam int DEF_GYRO_DIVISOR  = 5700;
  localparam int DEF_WALL_DIVISOR  = 50;
  localparam int DEF_LEFT_MIDDLE   = 1000;
  localparam int DEF_RIGHT_MIDDLE  = 1000;
  localparam int DEF_FRACTION_BITS = 8;

endpackage

FILE: hw/rtl/speed_ramp_pd_motor_control_core.sv
// ----------------------------------------------------------------------------
// speed_ramp_pd_motor_control_core - trapezoidal speed ramp with PD control
// Pipeline: a transaction passes the input register, six compute stages and
//   the output register.
// Throughput: one transaction per cycle unless out_tready stalls the output;
//   only s1 (encoder history) and s4 (speed/error) feed back state.
// Reset (rst_n low, synchronous): pipeline emptied, speeds, errors and encoder
//   history cleared, gain and step registers back to their default values.
// ----------------------------------------------------------------------------
module speed_ramp_pd_motor_control_core #(
  parameter int GYRO_DIVISOR  = srpd_pkg::DEF_GYRO_DIVISOR,
  parameter int WALL_DIVISOR  = srpd_pkg::DEF_WALL_DIVISOR,
  parameter int LEFT_MIDDLE   = srpd_pkg::DEF_LEFT_MIDDLE,
  parameter int RIGHT_MIDDLE  = srpd_pkg::DEF_RIGHT_MIDDLE,
  parameter int FRACTION_BITS = srpd_pkg::DEF_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] left_count, [63:32] right_count, [75:64] target_forward,
  // [87:76] target_turn, [111:88] gyro_rate, [123:112] left_wall,
  // [135:124] right_wall
  input  logic [srpd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] wall_enable, [2:1] feedback_mode
  input  logic [srpd_pkg::IN_TUSER_W-1:0]     in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] left_drive, [31:16] right_drive
  output logic [srpd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [srpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srpd_pkg::REG_W-1:0]          cfg_data
);

  // --------------------------------------------------------------------------
  // Widths
  // --------------------------------------------------------------------------
  localparam int CNT_W  = srpd_pkg::CNT_W;
  localparam int TGT_W  = srpd_pkg::TGT_W;
  localparam int GYRO_W = srpd_pkg::GYRO_W;
  localparam int WALL_W = srpd_pkg::WALL_W;
  localparam int MODE_W = srpd_pkg::MODE_W;
  localparam int DRV_W  = srpd_pkg::DRV_W;
  localparam int ERR_W  = srpd_pkg::ERR_W;
  localparam int REG_W  = srpd_pkg::REG_W;
  localparam int F      = FRACTION_BITS;

  localparam int NSTG   = 8;                         // s0 .. s7 (s7 = output)
  localparam int SPD_W  = TGT_W + F;                 // speed never leaves target range
  localparam int RMP_W  = ((SPD_W > REG_W + 1) ? SPD_W : REG_W + 1) + 1;
  localparam int FBF_W  = CNT_W + 1;                 // sum / difference of two deltas
  localparam int FBT_W  = FBF_W + 1;                 // encoder turn plus gyro
  localparam int DEL_W  = FBT_W + 1 + F;             // scaled feedback plus wall term
  localparam int ACC_W  = DEL_W + 2;                 // error + speed + delta
  localparam int PF_W   = ERR_W + REG_W + 1;         // kp * e
  localparam int DIF_W  = ERR_W + 1;                 // e - prior
  localparam int PD_W   = DIF_W + REG_W + 1;         // kd * (e - prior)
  localparam int SUM_W  = PD_W + 1;
  localparam int TERM_W = SUM_W - 2 * F;
  localparam int DS_W   = TERM_W + 1;

  localparam logic [WALL_W-1:0] LMID = WALL_W'(LEFT_MIDDLE);
  localparam logic [WALL_W-1:0] RMID = WALL_W'(RIGHT_MIDDLE);

  localparam logic signed [ACC_W-1:0] ERR_MAX = ACC_W'((64'sd1 <<< (ERR_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] ERR_MIN = -ERR_MAX - ACC_W'(1);
  localparam logic signed [DS_W-1:0]  DRV_MAX = DS_W'((64'sd1 <<< (DRV_W - 1)) - 64'sd1);
  localparam logic signed [DS_W-1:0]  DRV_MIN = -DRV_MAX - DS_W'(1);
  localparam logic signed [SUM_W-1:0] PD_BIAS = SUM_W'((64'sd1 <<< (2 * F)) - 64'sd1);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // Move speed toward target by one step, never past it
  function automatic logic signed [SPD_W-1:0] ramp(
    input logic signed [SPD_W-1:0] speed,
    input logic signed [SPD_W-1:0] target,
    input logic [REG_W-1:0]        up,
    input logic [REG_W-1:0]        down
  );
    logic signed [RMP_W-1:0] s;
    logic signed [RMP_W-1:0] t;
    logic signed [RMP_W-1:0] r;
    s = RMP_W'(speed);
    t = RMP_W'(target);
    r = s;
    if (s < t) begin
      r = s + $signed(RMP_W'(up));
      if (r > t) r = t;
    end else if (s > t) begin
      r = s - $signed(RMP_W'(down));
      if (r < t) r = t;
    end
    return SPD_W'(r);
  endfunction

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > ERR_MAX) c = ERR_MAX;
    else if (v < ERR_MIN) c = ERR_MIN;
    return ERR_W'(c);
  endfunction

  function automatic logic signed [DRV_W-1:0] sat_drv(input logic signed [DS_W-1:0] v);
    logic signed [DS_W-1:0] c;
    c = v;
    if (v > DRV_MAX) c = DRV_MAX;
    else if (v < DRV_MIN) c = DRV_MIN;
    return DRV_W'(c);
  endfunction

  // Drop the 2F fraction bits, rounding toward zero
  function automatic logic signed [TERM_W-1:0] pd_round(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] b;
    b = v[SUM_W-1] ? (v + PD_BIAS) : v;
    return TERM_W'(b >>> (2 * F));
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [REG_W-1:0] fwd_kp_r, fwd_kd_r, turn_kp_r, turn_kd_r;
  logic [REG_W-1:0] fwd_acc_r, fwd_dec_r, turn_acc_r, turn_dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_kp_r   <= srpd_pkg::RST_FWD_KP;
      fwd_kd_r   <= srpd_pkg::RST_FWD_KD;
      turn_kp_r  <= srpd_pkg::RST_TURN_KP;
      turn_kd_r  <= srpd_pkg::RST_TURN_KD;
      fwd_acc_r  <= srpd_pkg::RST_FWD_ACC;
      fwd_dec_r  <= srpd_pkg::RST_FWD_DEC;
      turn_acc_r <= srpd_pkg::RST_TURN_ACC;
      turn_dec_r <= srpd_pkg::RST_TURN_DEC;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        srpd_pkg::REG_FWD_KP:   fwd_kp_r   <= cfg_data;
        srpd_pkg::REG_FWD_KD:   fwd_kd_r   <= cfg_data;
        srpd_pkg::REG_TURN_KP:  turn_kp_r  <= cfg_data;
        srpd_pkg::REG_TURN_KD:  turn_kd_r  <= cfg_data;
        srpd_pkg::REG_FWD_ACC:  fwd_acc_r  <= cfg_data;
        srpd_pkg::REG_FWD_DEC:  fwd_dec_r  <= cfg_data;
        srpd_pkg::REG_TURN_ACC: turn_acc_r <= cfg_data;
        srpd_pkg::REG_TURN_DEC: turn_dec_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // Each stage holds its transaction until the next stage can take it, so bubbles
  // collapse and input flows into empty stages while the output is stalled.
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] adv;   // stage may load this cycle
  logic [NSTG-1:0] ld;    // stage loads a transaction this cycle

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    ld[0]      = in_tvalid && adv[0];
    vld_nxt[0] = adv[0] ? in_tvalid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      ld[k]      = vld_r[k-1] && adv[k];
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[NSTG-1];

  // --------------------------------------------------------------------------
  // s0: input register
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]         s0_lc_r, s0_rc_r;
  logic signed [TGT_W-1:0]  s0_tf_r, s0_tt_r;
  logic signed [GYRO_W-1:0] s0_gyro_r;
  logic [WALL_W-1:0]        s0_lw_r, s0_rw_r;
  logic                     s0_wall_on_r;
  logic [MODE_W-1:0]        s0_mode_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_lc_r      <= in_tdata[31:0];
      s0_rc_r      <= in_tdata[63:32];
      s0_tf_r      <= in_tdata[75:64];
      s0_tt_r      <= in_tdata[87:76];
      s0_gyro_r    <= in_tdata[111:88];
      s0_lw_r      <= in_tdata[123:112];
      s0_rw_r      <= in_tdata[135:124];
      s0_wall_on_r <= in_tuser[0];
      s0_mode_r    <= in_tuser[2:1];
    end
  end

  // --------------------------------------------------------------------------
  // s1: encoder deltas, gyro and wall error magnitudes
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]         last_left_r, last_right_r;
  logic signed [CNT_W-1:0]  s1_dl_r, s1_dr_r;
  logic [GYRO_W-1:0]        s1_gmag_r;
  logic                     s1_gneg_r;
  logic [WALL_W-1:0]        s1_wmag_r;
  logic                     s1_wneg_r;
  logic [MODE_W-1:0]        s1_mode_r;
  logic signed [TGT_W-1:0]  s1_tf_r, s1_tt_r;

  logic signed [CNT_W-1:0]  dl_nxt, dr_nxt;
  logic [GYRO_W-1:0]        gmag_nxt;
  logic signed [WALL_W:0]   lw_s, rw_s, werr;
  logic [WALL_W-1:0]        wmag_nxt;

  always_comb begin
    // counter deltas wrap modulo 2^32
    dl_nxt   = $signed(s0_lc_r - last_left_r);
    dr_nxt   = $signed(s0_rc_r - last_right_r);
    gmag_nxt = s0_gyro_r[GYRO_W-1] ? GYRO_W'(-s0_gyro_r) : GYRO_W'(s0_gyro_r);

    // wall error: both sides close, else left close, else right close
    lw_s = $signed({1'b0, s0_lw_r});
    rw_s = $signed({1'b0, s0_rw_r});
    werr = '0;
    if (s0_wall_on_r) begin
      if ((s0_lw_r > LMID) && (s0_rw_r > RMID)) werr = rw_s - lw_s;
      else if (s0_lw_r > LMID) werr = $signed({1'b0, LMID}) - lw_s;
      else if (s0_rw_r > RMID) werr = rw_s - $signed({1'b0, RMID});
    end
    wmag_nxt = werr[WALL_W] ? WALL_W'(-werr) : WALL_W'(werr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_left_r  <= '0;
      last_right_r <= '0;
    end else if (ld[1]) begin
      last_left_r  <= s0_lc_r;
      last_right_r <= s0_rc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_dl_r   <= dl_nxt;
      s1_dr_r   <= dr_nxt;
      s1_gmag_r <= gmag_nxt;
      s1_gneg_r <= s0_gyro_r[GYRO_W-1];
      s1_wmag_r <= wmag_nxt;
      s1_wneg_r <= werr[WALL_W];
      s1_mode_r <= s0_mode_r;
      s1_tf_r   <= s0_tf_r;
      s1_tt_r   <= s0_tt_r;
    end
  end

  // --------------------------------------------------------------------------
  // s2: encoder feedback sums, constant divides (truncate toward zero on the
  // magnitude, sign restored in s3)
  // --------------------------------------------------------------------------
  logic signed [FBF_W-1:0] s2_fbf_r, s2_fbe_r;
  logic [GYRO_W-1:0]       s2_gq_r;
  logic [WALL_W-1:0]       s2_wq_r;
  logic                    s2_gneg_r, s2_wneg_r;
  logic [MODE_W-1:0]       s2_mode_r;
  logic signed [TGT_W-1:0] s2_tf_r, s2_tt_r;

  srpd_cdiv #(
    .DIVISOR (GYRO_DIVISOR),
    .IN_W    (GYRO_W)
  ) u_gyro_div (
    .clk   (clk),
    .en    (ld[2]),
    .num   (s1_gmag_r),
    .quo_r (s2_gq_r)
  );

  srpd_cdiv #(
    .DIVISOR (WALL_DIVISOR),
    .IN_W    (WALL_W)
  ) u_wall_div (
    .clk   (clk),
    .en    (ld[2]),
    .num   (s1_wmag_r),
    .quo_r (s2_wq_r)
  );

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_fbf_r  <= FBF_W'(s1_dl_r) + FBF_W'(s1_dr_r);
      s2_fbe_r  <= FBF_W'(s1_dr_r) - FBF_W'(s1_dl_r);
      s2_gneg_r <= s1_gneg_r;
      s2_wneg_r <= s1_wneg_r;
      s2_mode_r <= s1_mode_r;
      s2_tf_r   <= s1_tf_r;
      s2_tt_r   <= s1_tt_r;
    end
  end

  // --------------------------------------------------------------------------
  // s3: feedback select, error increments in fixed point
  // --------------------------------------------------------------------------
  logic signed [DEL_W-1:0] s3_delf_r, s3_delt_r;
  logic signed [TGT_W-1:0] s3_tf_r, s3_tt_r;

  logic signed [GYRO_W:0]  gq_s;
  logic signed [WALL_W:0]  wq_s;
  logic signed [FBT_W-1:0] fbt;
  logic signed [DEL_W-1:0] delf_nxt, delt_nxt;

  always_comb begin
    gq_s = s2_gneg_r ? -$signed({1'b0, s2_gq_r}) : $signed({1'b0, s2_gq_r});
    wq_s = s2_wneg_r ? -$signed({1'b0, s2_wq_r}) : $signed({1'b0, s2_wq_r});
    case (s2_mode_r)
      srpd_pkg::FB_GYRO: fbt = FBT_W'(gq_s);
      srpd_pkg::FB_ENC:  fbt = FBT_W'(s2_fbe_r);
      default:           fbt = FBT_W'(s2_fbe_r) + FBT_W'(gq_s);
    endcase
    delf_nxt = (-DEL_W'(s2_fbf_r)) <<< F;
    delt_nxt = (DEL_W'(wq_s) - DEL_W'(fbt)) <<< F;
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_delf_r <= delf_nxt;
      s3_delt_r <= delt_nxt;
      s3_tf_r   <= s2_tf_r;
      s3_tt_r   <= s2_tt_r;
    end
  end

  // --------------------------------------------------------------------------
  // s4: speed ramp and error accumulation - the registered state loop.
  // The error registers double as this stage's output; prior holds the
  // error of the transaction before.
  // --------------------------------------------------------------------------
  logic signed [SPD_W-1:0] spd_f_r, spd_t_r;
  logic signed [ERR_W-1:0] err_f_r, err_t_r;
  logic signed [ERR_W-1:0] prior_f_r, prior_t_r;

  logic signed [SPD_W-1:0] tgt_f, tgt_t;
  logic signed [SPD_W-1:0] spd_f_nxt, spd_t_nxt;
  logic signed [ERR_W-1:0] err_f_nxt, err_t_nxt;

  always_comb begin
    tgt_f     = SPD_W'(s3_tf_r) <<< F;
    tgt_t     = SPD_W'(s3_tt_r) <<< F;
    spd_f_nxt = ramp(spd_f_r, tgt_f, fwd_acc_r, fwd_dec_r);
    spd_t_nxt = ramp(spd_t_r, tgt_t, turn_acc_r, turn_dec_r);
    err_f_nxt = sat_err(ACC_W'(err_f_r) + ACC_W'(spd_f_nxt) + ACC_W'(s3_delf_r));
    err_t_nxt = sat_err(ACC_W'(err_t_r) + ACC_W'(spd_t_nxt) + ACC_W'(s3_delt_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_f_r   <= '0;
      spd_t_r   <= '0;
      err_f_r   <= '0;
      err_t_r   <= '0;
      prior_f_r <= '0;
      prior_t_r <= '0;
    end else if (ld[4]) begin
      spd_f_r   <= spd_f_nxt;
      spd_t_r   <= spd_t_nxt;
      err_f_r   <= err_f_nxt;
      err_t_r   <= err_t_nxt;
      prior_f_r <= err_f_r;
      prior_t_r <= err_t_r;
    end
  end

  // --------------------------------------------------------------------------
  // s5: PD products
  // --------------------------------------------------------------------------
  logic signed [PF_W-1:0] s5_fp_r, s5_tp_r;
  logic signed [PD_W-1:0] s5_fd_r, s5_td_r;
  logic signed [DIF_W-1:0] dif_f, dif_t;

  always_comb begin
    dif_f = DIF_W'(err_f_r) - DIF_W'(prior_f_r);
    dif_t = DIF_W'(err_t_r) - DIF_W'(prior_t_r);
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s5_fp_r <= PF_W'($signed({1'b0, fwd_kp_r}))  * PF_W'(err_f_r);
      s5_fd_r <= PD_W'($signed({1'b0, fwd_kd_r}))  * PD_W'(dif_f);
      s5_tp_r <= PF_W'($signed({1'b0, turn_kp_r})) * PF_W'(err_t_r);
      s5_td_r <= PD_W'($signed({1'b0, turn_kd_r})) * PD_W'(dif_t);
    end
  end

  // --------------------------------------------------------------------------
  // s6: PD terms back to integer counts
  // --------------------------------------------------------------------------
  logic signed [TERM_W-1:0] s6_pf_r, s6_pt_r;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s6_pf_r <= pd_round(SUM_W'(s5_fp_r) + SUM_W'(s5_fd_r));
      s6_pt_r <= pd_round(SUM_W'(s5_tp_r) + SUM_W'(s5_td_r));
    end
  end

  // --------------------------------------------------------------------------
  // s7: wheel mix and saturation into the output register
  // --------------------------------------------------------------------------
  logic signed [DRV_W-1:0] left_nxt, right_nxt;

  always_comb begin
    left_nxt  = sat_drv(DS_W'(s6_pf_r) - DS_W'(s6_pt_r));
    right_nxt = sat_drv(DS_W'(s6_pf_r) + DS_W'(s6_pt_r));
  end

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      out_tdata <= {right_nxt, left_nxt};
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // error state moves only when the loop stage takes a transaction
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ld[4] |=> ($stable(err_f_r) && $stable(err_t_r)))
    else $error("error state changed without a transaction");

  // prior error is the error of the previous transaction
  a_prior: assert property (@(posedge clk) disable iff (!rst_n)
    ld[4] |=> (prior_f_r == $past(err_f_r) && prior_t_r == $past(err_t_r)))
    else $error("prior error not taken from previous error");

  // forward speed that already sits on its target stays there
  a_ramp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ld[4] && (spd_f_r == tgt_f)) |=> $stable(spd_f_r))
    else $error("forward speed left its target");

  // an empty input register never blocks input, whatever the output does
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_tready)
    else $error("input stalled with an empty input register");

  // left encoder history follows the transaction that passed into s1
  a_last_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ld[1] |=> (last_left_r == $past(s0_lc_r)))
    else $error("encoder history not updated");

endmodule

FILE: hw/rtl/srpd_cdiv.sv
// ----------------------------------------------------------------------------
// srpd_cdiv - registered unsigned divide by a constant
// Reciprocal multiply with a rounded-up multiplier; exact for every input
// below 2^IN_W, so no correction step is needed.
// ----------------------------------------------------------------------------
module srpd_cdiv #(
  parameter int DIVISOR = srpd_pkg::DEF_WALL_DIVISOR,
  parameter int IN_W    = srpd_pkg::WALL_W
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IN_W-1:0] num,
  output logic [IN_W-1:0] quo_r
);

  localparam int SH     = IN_W + $clog2(DIVISOR);
  localparam int M_W    = IN_W + 1;
  localparam int PROD_W = IN_W + M_W;
  localparam longint unsigned POW = 64'd1 << SH;
  localparam logic [M_W-1:0] RECIP = M_W'((POW + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [PROD_W-1:0] prod;
  logic [IN_W-1:0]   quo_nxt;

  always_comb begin
    prod    = PROD_W'(num) * PROD_W'(RECIP);
    quo_nxt = IN_W'(prod >> SH);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

endmodule
